// ----- rtl/u8u16_pkg.sv -----
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_PAGE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_STRICT    = 1'b1;

  // Code pages that select UTF-8 decoding
  localparam logic [15:0] CP_UTF8    = 16'd65001;
  localparam logic [15:0] CP_ACP     = 16'd0;
  localparam logic [15:0] CP_CONSOLE = 16'd1;
  localparam logic [15:0] CP_THREAD  = 16'd3;
  localparam logic [15:0] CP_RESET   = CP_UTF8;

  localparam logic [15:0] REPL_UNIT    = 16'h003F;
  localparam logic [15:0] SURR_HI_BASE = 16'hD800;
  localparam logic [15:0] SURR_LO_BASE = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h010000;
  localparam logic [20:0] BMP_MAX      = 21'h00FFFF;
  localparam logic [20:0] CODE_MAX     = 21'h10FFFF;
  localparam logic [20:0] SURR_FIRST   = 21'h00D800;
  localparam logic [20:0] SURR_LAST    = 21'h00DFFF;

  localparam int MAX_UNITS = 4;

  typedef struct packed {
    logic utf8;
    logic strict;
  } cfg_t;

  typedef struct packed {
    logic [20:0] value;
    logic [2:0]  exp_len;
    logic [1:0]  held;
    logic        drop;
  } dec_state_t;

  // Results caused by one byte, handed from decoder to output buffer
  typedef struct packed {
    logic [MAX_UNITS-1:0][15:0] units;
    logic [1:0]                 last_idx;
    logic                       any;
    logic                       str_end;
    logic                       err;
  } dec_result_t;

endpackage

// ----- rtl/u8u16_if.sv -----
// ----------------------------------------------------------------------------
// u8u16_if
// Valid/ready channels for source bytes and UTF-16 code units.
// ----------------------------------------------------------------------------
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, in_byte, last_byte, input ready);
  modport sink   (input valid, in_byte, last_byte, output ready);
endinterface

interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        run_last;
  logic        string_end;
  logic        bad_sequence;

  modport source (output valid, code_unit, run_last, string_end, bad_sequence,
                  input ready);
  modport sink   (input valid, code_unit, run_last, string_end, bad_sequence,
                  output ready);
endinterface

// ----- rtl/u8u16_decode.sv -----
// ----------------------------------------------------------------------------
// u8u16_decode
// Sequence state and per-byte decode into up to four code units.
// ----------------------------------------------------------------------------
module u8u16_decode
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        accept,
  input  logic [7:0]  in_byte,
  input  logic        last_byte,
  output dec_result_t res
);

  dec_state_t  st;
  dec_state_t  st_next;
  logic        lead_ascii;
  logic [2:0]  lead_need;
  logic [20:0] lead_bits;
  logic        lead_early;
  logic        lead_bad;
  logic [15:0] lead_unit;
  logic        cont;
  logic [20:0] pv_new;
  logic [1:0]  bh_new;
  logic        done;
  logic [2:0]  q_int;
  logic [2:0]  q_trunc;
  logic        overlong;
  logic        v_bad;
  logic [20:0] d;
  logic [2:0]  cnt;

  // Lead byte classification
  always_comb begin
    lead_ascii = ~in_byte[7];
    priority if (in_byte[7:5] == 3'b110) begin
      lead_need  = 3'd2;
      lead_bits  = {16'd0, in_byte[4:0]};
      lead_early = (in_byte[4:1] == 4'd0);
    end else if (in_byte[7:4] == 4'b1110) begin
      lead_need  = 3'd3;
      lead_bits  = {17'd0, in_byte[3:0]};
      lead_early = 1'b0;
    end else if (in_byte[7:3] == 5'b11110) begin
      lead_need  = 3'd4;
      lead_bits  = {18'd0, in_byte[2:0]};
      lead_early = (in_byte[2:0] > 3'd4);
    end else begin
      lead_need  = 3'd0;
      lead_bits  = '0;
      lead_early = 1'b0;
    end
    lead_bad  = (lead_need == 3'd0) || (cfg.strict && lead_early) || last_byte;
    lead_unit = lead_ascii ? {8'd0, in_byte} : REPL_UNIT;
  end

  always_comb begin
    cont    = (in_byte[7:6] == 2'b10);
    pv_new  = {st.value[14:0], in_byte[5:0]};
    bh_new  = st.held + 2'd1;
    done    = ({1'b0, bh_new} + 3'd1) >= st.exp_len;
    q_int   = {1'b0, st.held} + 3'd1;
    q_trunc = {1'b0, bh_new} + 3'd1;

    overlong = ((st.exp_len == 3'd2) && (pv_new < 21'h80)) ||
               ((st.exp_len == 3'd3) && (pv_new < 21'h800)) ||
               ((st.exp_len == 3'd4) && (pv_new < SUPP_BASE));
    v_bad    = overlong || (pv_new > CODE_MAX) ||
               ((pv_new >= SURR_FIRST) && (pv_new <= SURR_LAST));
    d        = pv_new - SUPP_BASE;

    st_next   = st;
    res.units = '0;
    res.err   = 1'b0;
    cnt       = 3'd0;

    if (!cfg.utf8) begin
      // pass-through: zero-extend and wipe decoder state
      st_next      = '0;
      res.units[0] = {8'd0, in_byte};
      cnt          = 3'd1;
    end else if (st.drop) begin
      if (last_byte) begin
        st_next.drop = 1'b0;
      end
    end else if (st.exp_len == 3'd0) begin
      if (lead_ascii) begin
        res.units[0] = lead_unit;
        cnt          = 3'd1;
      end else if (lead_bad) begin
        if (cfg.strict) begin
          res.err      = 1'b1;
          st_next.drop = ~last_byte;
        end else begin
          res.units[0] = REPL_UNIT;
        end
        cnt = 3'd1;
      end else begin
        st_next.value   = lead_bits;
        st_next.exp_len = lead_need;
        st_next.held    = 2'd0;
      end
    end else if (cont) begin
      if (done) begin
        st_next.value   = '0;
        st_next.exp_len = '0;
        st_next.held    = '0;
        if (cfg.strict && v_bad) begin
          res.err      = 1'b1;
          st_next.drop = ~last_byte;
          cnt          = 3'd1;
        end else if (pv_new > BMP_MAX) begin
          // split into a surrogate pair, high unit first
          res.units[0] = SURR_HI_BASE + {5'd0, d[20:10]};
          res.units[1] = SURR_LO_BASE | {6'd0, d[9:0]};
          cnt          = 3'd2;
        end else begin
          res.units[0] = pv_new[15:0];
          cnt          = 3'd1;
        end
      end else if (last_byte) begin
        // truncated sequence at end of string
        st_next.value   = '0;
        st_next.exp_len = '0;
        st_next.held    = '0;
        if (cfg.strict) begin
          res.err = 1'b1;
          cnt     = 3'd1;
        end else begin
          for (int i = 0; i < MAX_UNITS; i++) begin
            if (3'(i) < q_trunc) begin
              res.units[i] = REPL_UNIT;
            end
          end
          cnt = q_trunc;
        end
      end else begin
        st_next.value = pv_new;
        st_next.held  = bh_new;
      end
    end else begin
      // interrupted sequence
      st_next.value   = '0;
      st_next.exp_len = '0;
      st_next.held    = '0;
      if (cfg.strict) begin
        res.err      = 1'b1;
        st_next.drop = ~last_byte;
        cnt          = 3'd1;
      end else begin
        for (int i = 0; i < MAX_UNITS; i++) begin
          if (3'(i) < q_int) begin
            res.units[i] = REPL_UNIT;
          end
        end
        if (lead_ascii || lead_bad) begin
          res.units[q_int[1:0]] = lead_unit;
          cnt = q_int + 3'd1;
        end else begin
          st_next.value   = lead_bits;
          st_next.exp_len = lead_need;
          cnt             = q_int;
        end
      end
    end

    res.any      = (cnt != 3'd0);
    res.last_idx = 2'(cnt - 3'd1);
    res.str_end  = last_byte || res.err;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (accept) begin
      st <= st_next;
    end
  end

endmodule

// ----- rtl/u8u16_emit.sv -----
// ----------------------------------------------------------------------------
// u8u16_emit
// Result buffer: holds the units of one byte and drains one per cycle while units.ready is high.
// ----------------------------------------------------------------------------
module u8u16_emit
  import u8u16_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  dec_result_t         res,
  output logic                take_ok,
  u8u16_unit_if.source        units
);

  logic                       busy;
  logic [MAX_UNITS-1:0][15:0] buf_units;
  logic [1:0]                 last_idx;
  logic [1:0]                 idx;
  logic                       str_end;
  logic                       err;
  logic                       at_last;
  logic                       xfer;

  assign at_last = (idx == last_idx);
  assign xfer    = busy && units.ready;
  // take a new byte when empty, or when the final unit leaves this cycle
  assign take_ok = !busy || (units.ready && at_last);

  assign units.valid        = busy;
  assign units.code_unit    = buf_units[idx];
  assign units.run_last     = at_last;
  assign units.string_end   = at_last && str_end;
  assign units.bad_sequence = err;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load && res.any) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (xfer) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.any) begin
      buf_units <= res.units;
      last_idx  <= res.last_idx;
      str_end   <= res.str_end;
      err       <= res.err;
    end
  end

endmodule

// ----- rtl/utf8_to_utf16_transcoder_top.sv -----
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_top
// Byte stream in, UTF-16 code units out, with lenient or strict UTF-8 rules or zero-extending pass-through.
// ----------------------------------------------------------------------------
// One source byte is taken per transfer on the bytes channel, with last_byte
// marking the end of a string. Each byte is decoded in the cycle it is taken
// and its code units (zero to four) land in a result buffer that drains one
// unit per cycle on the units channel while units.ready is high. Plain text,
// one or no unit per byte, streams at one byte per clock while units.ready
// is high; a byte that yields more units holds the bytes channel until they
// have all left, since the single result buffer empties one unit per clock.
// The next byte is taken in the same cycle the last buffered unit leaves.
// run_last marks the last unit of each byte, string_end the last unit of a
// string or an error result, and bad_sequence a strict-mode error, after
// which bytes up to the next last_byte mark give no units. Write code_page
// and strict_check only while the block is idle.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder_top
  import u8u16_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  u8u16_byte_if.sink           bytes,
  u8u16_unit_if.source         units
);

  logic [15:0] code_page;
  logic        strict_check;
  cfg_t        cfg;
  logic        take_ok;
  logic        accept;
  dec_result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      code_page    <= CP_RESET;
      strict_check <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CODE_PAGE: code_page    <= cfg_data;
        REG_STRICT:    strict_check <= cfg_data[0];
        default:       ;
      endcase
    end
  end

  assign cfg.utf8   = (code_page == CP_ACP) || (code_page == CP_CONSOLE) ||
                      (code_page == CP_THREAD) || (code_page == CP_UTF8);
  assign cfg.strict = strict_check;

  // A byte transfer decodes immediately and loads the result buffer if it yields any unit
  assign bytes.ready = take_ok;
  assign accept      = bytes.valid && take_ok;

  u8u16_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .accept    (accept),
    .in_byte   (bytes.in_byte),
    .last_byte (bytes.last_byte),
    .res       (res)
  );

  u8u16_emit u_emit (
    .clk     (clk),
    .rst     (rst),
    .load    (accept),
    .res     (res),
    .take_ok (take_ok),
    .units   (units)
  );

endmodule
